>>> rtl/assert_macros.svh
// assertion macros shared by the placer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, disabled while in reset
`define FFP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("ffp assertion failed");

// next-cycle implication built on the plain check
`define FFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	`FFP_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

>>> rtl/ffp_pkg.sv
// types and constants shared by the first-fit rectangle placer
package ffp_pkg;

	// grid geometry
	localparam int GRID_SIDE = 16;
	localparam int CRD_W     = $clog2(GRID_SIDE);
	localparam int AREA_W    = $clog2(GRID_SIDE * GRID_SIDE + 1);

	// request and result field widths
	localparam int ID_W      = 8;
	localparam int DIM_W     = 5;
	localparam int POS_W     = 4;
	localparam int AREA_O_W  = 9;
	localparam int COUNT_W   = 8;

	// request action codes
	localparam logic ACT_PLACE = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_CLR,
		S_ACC,
		S_CHK,
		S_FILL,
		S_RESP
	} st_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic clr;
		logic acc;
		logic chk;
		logic fill;
		logic resp_ld;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_req;
		logic bad;
		logic row_last;
		logic y_last;
		logic fit_any;
	} sts_t;

endpackage

>>> rtl/ffp_req_if.sv
// request channel of the placer
interface ffp_req_if import ffp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              action;
	logic [ID_W-1:0]   item_id;
	logic [DIM_W-1:0]  rect_width;
	logic [DIM_W-1:0]  rect_height;

	modport source (output valid, action, item_id, rect_width, rect_height, input ready);
	modport sink   (input valid, action, item_id, rect_width, rect_height, output ready);
endinterface

>>> rtl/ffp_rsp_if.sv
// result channel of the placer
interface ffp_rsp_if import ffp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                placed;
	logic [POS_W-1:0]    pos_x;
	logic [POS_W-1:0]    pos_y;
	logic [AREA_O_W-1:0] used_area;
	logic [COUNT_W-1:0]  placed_count;

	modport source (output valid, placed, pos_x, pos_y, used_area, placed_count, input ready);
	modport sink   (input valid, placed, pos_x, pos_y, used_area, placed_count, output ready);
endinterface

>>> rtl/ffp_ctrl.sv
// controller state machine of the placer
`include "assert_macros.svh"

module ffp_ctrl import ffp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	st_t  st_q, st_d;
	logic out_valid_q;
	logic out_free;
	logic accept;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (st_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = out_valid_q;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: begin
				if (accept) begin
					if (sts.clr_req) st_d = S_CLR;
					else if (sts.bad) st_d = S_RESP;
					else st_d = S_ACC;
				end
			end
			S_CLR:  st_d = S_RESP;
			S_ACC: begin
				if (sts.row_last) st_d = S_CHK;
			end
			S_CHK: begin
				if (sts.fit_any) st_d = S_FILL;
				else if (sts.y_last) st_d = S_RESP;
				else st_d = S_ACC;
			end
			S_FILL: begin
				if (sts.row_last) st_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) st_d = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd         = '0;
		cmd.load    = accept;
		cmd.clr     = (st_q == S_CLR);
		cmd.acc     = (st_q == S_ACC);
		cmd.chk     = (st_q == S_CHK);
		cmd.fill    = (st_q == S_FILL);
		cmd.resp_ld = (st_q == S_RESP) && out_free;
	end

	// state and result valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cmd.resp_ld) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	`FFP_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, st_q != S_IDLE)
	`FFP_ASSERT_NEXT(a_resp_done, clk, arst_n, (st_q == S_RESP) && out_free,
		(st_q == S_IDLE) && out_valid_q)
	`FFP_ASSERT_NEXT(a_resp_wait, clk, arst_n, (st_q == S_RESP) && out_valid_q && !rsp_ready,
		st_q == S_RESP)

endmodule

>>> rtl/ffp_dpath.sv
// occupancy rows, anchor check, fill and counters of the placer
`include "assert_macros.svh"

module ffp_dpath import ffp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic                action,
	input  logic [ID_W-1:0]     item_id,
	input  logic [DIM_W-1:0]    rect_width,
	input  logic [DIM_W-1:0]    rect_height,
	output logic                placed,
	output logic [POS_W-1:0]    pos_x,
	output logic [POS_W-1:0]    pos_y,
	output logic [AREA_O_W-1:0] used_area,
	output logic [COUNT_W-1:0]  placed_count
);

	logic [GRID_SIDE-1:0] row_q [GRID_SIDE];
	logic [GRID_SIDE-1:0] acc_q;
	logic [DIM_W-1:0]     w_q, h_q;
	logic [CRD_W-1:0]     y_q, r_q, px_q;
	logic                 placed_q;
	logic [AREA_W-1:0]    area_q;
	logic [COUNT_W-1:0]   count_q;

	logic [CRD_W-1:0]     row_idx;
	logic [GRID_SIDE-1:0] row_rd;
	logic [GRID_SIDE:0]   wm_full;
	logic [GRID_SIDE-1:0] wmask;
	logic [GRID_SIDE-1:0] fill_mask;
	logic [GRID_SIDE-1:0] fit;
	logic [CRD_W-1:0]     first_x;
	logic [2*DIM_W-1:0]   rect_area;

	// row address and read
	assign row_idx = y_q + r_q;
	assign row_rd  = row_q[row_idx];

	// run of ones as wide as the rectangle
	assign wm_full   = (GRID_SIDE+1)'(1) << w_q;
	assign wmask     = GRID_SIDE'(wm_full - (GRID_SIDE+1)'(1));
	assign fill_mask = wmask << px_q;
	assign rect_area = w_q * h_q;

	// one lane per column anchor against the merged rows
	always_comb begin
		for (int x = 0; x < GRID_SIDE; x++) begin
			fit[x] = (int'(w_q) + x <= GRID_SIDE) && (((acc_q >> x) & wmask) == '0);
		end
	end

	// leftmost fitting column
	always_comb begin
		first_x = '0;
		for (int x = GRID_SIDE - 1; x >= 0; x--) begin
			if (fit[x]) first_x = CRD_W'(x);
		end
	end

	// status for the controller
	always_comb begin
		sts          = '0;
		sts.clr_req  = (action == ACT_CLEAR);
		sts.bad      = (item_id == '0) || (rect_width == '0) || (rect_height == '0)
			|| (int'(rect_width) > GRID_SIDE) || (int'(rect_height) > GRID_SIDE);
		sts.row_last = (r_q == CRD_W'(h_q - DIM_W'(1)));
		sts.y_last   = (y_q == CRD_W'(GRID_SIDE - int'(h_q)));
		sts.fit_any  = |fit;
	end

	// grid and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GRID_SIDE; i++) row_q[i] <= '0;
			area_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.clr) begin
				for (int i = 0; i < GRID_SIDE; i++) row_q[i] <= '0;
				area_q  <= '0;
				count_q <= '0;
			end else if (cmd.fill) begin
				row_q[row_idx] <= row_rd | fill_mask;
				if (sts.row_last) begin
					area_q <= area_q + AREA_W'(rect_area);
					if (count_q != '1) count_q <= count_q + COUNT_W'(1);
				end
			end
		end
	end

	// scan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			placed_q <= 1'b0;
		end else begin
			if (cmd.load) placed_q <= 1'b0;
			else if (cmd.fill && sts.row_last) placed_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q   <= rect_width;
			h_q   <= rect_height;
			y_q   <= '0;
			r_q   <= '0;
			px_q  <= '0;
			acc_q <= '0;
		end else if (cmd.acc || cmd.fill) begin
			if (cmd.acc) acc_q <= acc_q | row_rd;
			r_q <= sts.row_last ? '0 : r_q + CRD_W'(1);
		end else if (cmd.chk) begin
			if (sts.fit_any) begin
				px_q <= first_x;
			end else begin
				y_q   <= y_q + CRD_W'(1);
				acc_q <= '0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.resp_ld) begin
			placed       <= placed_q;
			pos_x        <= placed_q ? POS_W'(px_q) : '0;
			pos_y        <= placed_q ? POS_W'(y_q) : '0;
			used_area    <= AREA_O_W'(area_q);
			placed_count <= count_q;
		end
	end

	`FFP_ASSERT(a_fill_empty, clk, arst_n, cmd.fill |-> ((row_rd & fill_mask) == '0))
	`FFP_ASSERT(a_area_bound, clk, arst_n, area_q <= AREA_W'(GRID_SIDE * GRID_SIDE))

endmodule

>>> rtl/first_fit_grid_rect_placer_unit.sv
// top level of the first-fit rectangle placer on a square occupancy grid
// clear: clear state, then result state; zero id or bad size: straight to result state
// place of height h: up to GRID_SIDE-h+1 anchor rows, each merging its h rows, one row
// read per cycle, then checked; the fill state writes the h rows when placed, then the result
// one request in flight; the next is taken the cycle after a result loads, even if it waits
// reset empties the grid and zeroes both counters at once
module first_fit_grid_rect_placer_unit import ffp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	ffp_req_if.sink          req,
	ffp_rsp_if.source        rsp
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	ffp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// grid and result datapath
	ffp_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.action       (req.action),
		.item_id      (req.item_id),
		.rect_width   (req.rect_width),
		.rect_height  (req.rect_height),
		.placed       (rsp.placed),
		.pos_x        (rsp.pos_x),
		.pos_y        (rsp.pos_y),
		.used_area    (rsp.used_area),
		.placed_count (rsp.placed_count)
	);

endmodule

>>> bench/first_fit_grid_rect_placer_unit_test.sv
// self-checking bench for the first-fit rectangle placer with a shadow grid predictor
`timescale 1ns / 100ps

module first_fit_grid_rect_placer_unit_test;
	import ffp_pkg::*;

	localparam int CELLS        = GRID_SIDE * GRID_SIDE;
	localparam int COUNT_SAT    = (1 << COUNT_W) - 1;
	localparam int TARGET_ITEMS = 1750;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic              action;
		logic [ID_W-1:0]   item_id;
		logic [DIM_W-1:0]  rect_width;
		logic [DIM_W-1:0]  rect_height;
	} place_req_t;

	typedef struct packed {
		logic                placed;
		logic [POS_W-1:0]    pos_x;
		logic [POS_W-1:0]    pos_y;
		logic [AREA_O_W-1:0] used_area;
		logic [COUNT_W-1:0]  placed_count;
	} place_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	ffp_req_if req_ch ();
	ffp_rsp_if rsp_ch ();

	first_fit_grid_rect_placer_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the occupancy grid and counters
	logic [ID_W-1:0] shadow_grid [CELLS];
	int              shadow_area;
	int              shadow_count;

	place_req_t pending_reqs[$];
	place_rsp_t outstanding_results[$];
	place_req_t next_req;
	place_req_t taken_req;
	place_rsp_t oldest_result;

	int total_items;
	int phase_len;
	int hold_at;
	int items_sent;
	int mismatch_count;
	int hold_left;
	bit hold_done;
	bit req_taken;

	// clock
	always #5 clk = ~clk;

	// idle percentage of one side for the current phase
	function automatic int idle_pct(bit sender);
		if (items_sent < phase_len) begin
			return sender ? 10 : 59;
		end else if (items_sent < 2 * phase_len) begin
			return sender ? 59 : 10;
		end
		return 0;
	endfunction

	// first-fit scan on the shadow grid, returns the result the block should give
	function automatic place_rsp_t predict_placement(place_req_t r);
		place_rsp_t res;
		int w, h, x, y, row, col;
		bit found, fits;
		res   = '0;
		found = 1'b0;
		w     = r.rect_width;
		h     = r.rect_height;
		if (r.action == ACT_CLEAR) begin
			foreach (shadow_grid[i]) shadow_grid[i] = '0;
			shadow_area  = 0;
			shadow_count = 0;
		end else if (r.item_id != '0 && w != 0 && h != 0) begin
			for (y = 0; y < GRID_SIDE && !found; y++) begin
				for (x = 0; x < GRID_SIDE && !found; x++) begin
					fits = (x + w <= GRID_SIDE) && (y + h <= GRID_SIDE);
					for (row = y; fits && row < y + h; row++) begin
						for (col = x; fits && col < x + w; col++) begin
							if (shadow_grid[row * GRID_SIDE + col] != '0) fits = 1'b0;
						end
					end
					if (fits) begin
						for (row = y; row < y + h; row++) begin
							for (col = x; col < x + w; col++) begin
								shadow_grid[row * GRID_SIDE + col] = r.item_id;
							end
						end
						shadow_area += w * h;
						if (shadow_count < COUNT_SAT) shadow_count++;
						res.pos_x = POS_W'(x);
						res.pos_y = POS_W'(y);
						found     = 1'b1;
					end
				end
			end
		end
		res.placed       = found;
		res.used_area    = AREA_O_W'(shadow_area);
		res.placed_count = COUNT_W'(shadow_count);
		return res;
	endfunction

	task automatic queue_request(logic act, int id, int w, int h);
		place_req_t r;
		r.action      = act;
		r.item_id     = ID_W'(id);
		r.rect_width  = DIM_W'(w);
		r.rect_height = DIM_W'(h);
		pending_reqs.push_back(r);
	endtask

	// rectangle side, mostly small, now and then large, zero or oversized
	function automatic int pick_dim();
		int r;
		r = $urandom_range(99);
		if (r < 78) return $urandom_range(4, 1);
		if (r < 90) return $urandom_range(10, 5);
		if (r < 93) return $urandom_range(16, 11);
		if (r < 96) return 0;
		return $urandom_range(31, 17);
	endfunction

	function automatic int pick_id();
		return ($urandom_range(99) < 5) ? 0 : $urandom_range(255, 1);
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// request driver, changes inputs at the falling edge
	always @(negedge clk) begin
		if (arst_n && (!req_ch.valid || req_taken)) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
				next_req = pending_reqs.pop_front();
				req_ch.valid       <= 1'b1;
				req_ch.action      <= next_req.action;
				req_ch.item_id     <= next_req.item_id;
				req_ch.rect_width  <= next_req.rect_width;
				req_ch.rect_height <= next_req.rect_height;
			end else begin
				// junk payload while idle
				req_ch.valid       <= 1'b0;
				req_ch.action      <= $urandom;
				req_ch.item_id     <= $urandom;
				req_ch.rect_width  <= $urandom;
				req_ch.rect_height <= $urandom;
			end
		end
	end

	// result receiver with random stalls and one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else if (!hold_done && items_sent >= hold_at) begin
			rsp_ch.ready <= 1'b0;
			hold_left    <= HOLD_CYCLES;
			hold_done    <= 1'b1;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= idle_pct(1'b0));
		end
	end

	// monitor: check each result, then predict for each request taken
	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= req_ch.valid && req_ch.ready;
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
				if (outstanding_results.size() == 0) begin
					$error("result arrived with no request outstanding");
					mismatch_count++;
				end else begin
					oldest_result = outstanding_results.pop_front();
					check_field("placed", oldest_result.placed, rsp_ch.placed);
					check_field("pos_x", oldest_result.pos_x, rsp_ch.pos_x);
					check_field("pos_y", oldest_result.pos_y, rsp_ch.pos_y);
					check_field("used_area", oldest_result.used_area, rsp_ch.used_area);
					check_field("placed_count", oldest_result.placed_count,
						rsp_ch.placed_count);
				end
			end
			if (req_ch.valid && req_ch.ready === 1'b1) begin
				taken_req = {req_ch.action, req_ch.item_id, req_ch.rect_width,
					req_ch.rect_height};
				outstanding_results.push_back(predict_placement(taken_req));
				items_sent++;
			end
		end
	end

	// overall time limit
	initial begin
		#15000000;
		$display("FAIL first_fit_grid_rect_placer_unit");
		$finish;
	end

	// stimulus, reset and end of run
	initial begin
		int kind, n;
		bit saturation_done;
		req_ch.valid       = 1'b0;
		req_ch.action      = ACT_PLACE;
		req_ch.item_id     = '0;
		req_ch.rect_width  = '0;
		req_ch.rect_height = '0;
		rsp_ch.ready       = 1'b0;
		arst_n             = 1'b0;
		items_sent         = 0;
		mismatch_count     = 0;
		hold_left          = 0;
		hold_done          = 1'b0;
		req_taken          = 1'b0;
		saturation_done    = 1'b0;
		foreach (shadow_grid[i]) shadow_grid[i] = '0;
		shadow_area  = 0;
		shadow_count = 0;

		// directed: full grid, no fit, degenerate sizes, zero id, oversize
		queue_request(ACT_PLACE, 255, 16, 16);
		queue_request(ACT_PLACE, 1, 1, 1);
		queue_request(ACT_CLEAR, 255, 31, 31);
		queue_request(ACT_PLACE, 7, 0, 5);
		queue_request(ACT_PLACE, 7, 5, 0);
		queue_request(ACT_PLACE, 0, 1, 1);
		queue_request(ACT_PLACE, 9, 17, 1);
		queue_request(ACT_PLACE, 9, 1, 17);
		queue_request(ACT_PLACE, 9, 31, 31);
		queue_request(ACT_PLACE, 128, 16, 1);
		queue_request(ACT_PLACE, 3, 1, 15);
		queue_request(ACT_PLACE, 4, 15, 15);
		queue_request(ACT_PLACE, 5, 1, 1);
		queue_request(ACT_PLACE, 6, 1, 1);
		queue_request(ACT_PLACE, 85, 2, 2);
		queue_request(ACT_CLEAR, 0, 0, 0);
		queue_request(ACT_PLACE, 170, 3, 7);
		queue_request(ACT_PLACE, 17, 14, 9);
		queue_request(ACT_PLACE, 18, 13, 16);
		queue_request(ACT_PLACE, 19, 16, 16);
		queue_request(ACT_CLEAR, 42, 16, 16);

		// random episodes until the item target is reached
		while (pending_reqs.size() < TARGET_ITEMS) begin
			kind = $urandom_range(99);
			if (!saturation_done && pending_reqs.size() >= 600) begin
				// unit squares until the grid is full and the count saturates
				queue_request(ACT_CLEAR, $urandom, $urandom, $urandom);
				for (int i = 0; i < CELLS + 1; i++) queue_request(ACT_PLACE,
					$urandom_range(255, 1), 1, 1);
				saturation_done = 1'b1;
			end else if (kind < 75) begin
				// fill a fresh grid with a random batch of places
				queue_request(ACT_CLEAR, $urandom, $urandom, $urandom);
				n = $urandom_range(70, 15);
				for (int i = 0; i < n; i++) queue_request(ACT_PLACE, pick_id(),
					pick_dim(), pick_dim());
			end else if (kind < 90) begin
				// noise over the full width of every field
				n = $urandom_range(20, 5);
				for (int i = 0; i < n; i++) queue_request(($urandom_range(99) < 15) ?
					ACT_CLEAR : ACT_PLACE, $urandom, $urandom, $urandom);
			end else begin
				// more places on whatever grid is left
				n = $urandom_range(30, 5);
				for (int i = 0; i < n; i++) queue_request(ACT_PLACE, pick_id(),
					pick_dim(), pick_dim());
			end
		end
		total_items = pending_reqs.size();
		phase_len   = total_items / 3;
		hold_at     = 2 * phase_len + 10;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		while (items_sent < total_items) @(posedge clk);
		while (outstanding_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS first_fit_grid_rect_placer_unit");
		end else begin
			$display("FAIL first_fit_grid_rect_placer_unit");
		end
		$finish;
	end

endmodule
